// File: rtl/ipuc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipuc_pkg: shared types and constants of the IPv4/UDP checksum checker
// Frame layout offsets, the queue entry type and the ones-complement add.
// ----------------------------------------------------------------------------
package ipuc_pkg;

	// Frame position counter width and its saturation value
	localparam int unsigned POS_W = 17;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// Ethernet layout
	localparam logic [POS_W-1:0] ETH_TYPE_HI = 17'd12;
	localparam logic [POS_W-1:0] ETH_TYPE_LO = 17'd13;
	localparam logic [POS_W-1:0] ETH_HDR_BYTES = 17'd14;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

	// IPv4 header offsets, relative to the start of the header
	localparam logic [5:0] IP_OFF_PROTO = 6'd9;
	localparam logic [5:0] IP_OFF_CSUM_LO = 6'd11;
	localparam logic [5:0] IP_OFF_SRC_HI = 6'd12;
	localparam logic [5:0] IP_OFF_DST_LO = 6'd19;
	localparam logic [5:0] IP_MIN_HDR_BYTES = 6'd20;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;

	// UDP header offsets, relative to the start of the datagram
	localparam logic [POS_W-1:0] UDP_OFF_LEN_HI = 17'd4;
	localparam logic [POS_W-1:0] UDP_OFF_LEN_LO = 17'd5;
	localparam logic [POS_W-1:0] UDP_OFF_CSUM_HI = 17'd6;
	localparam logic [POS_W-1:0] UDP_OFF_CSUM_LO = 17'd7;
	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

	// Pseudo-header protocol word; seeds the UDP sum at frame start
	localparam logic [15:0] UDP_SUM_SEED = 16'h0011;

	// Command queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	// One command for the back end
	typedef struct packed {
		logic [15:0] word;
		logic        add_ip;
		logic        add_udp;
		logic        set_ip_field;
		logic        set_udp_field;
		logic        last;
		logic        emit;
		logic        trunc;
	} ipuc_op_t;

	// 16-bit ones-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[16]) begin
			return s[15:0] + 16'd1;
		end
		return s[15:0];
	endfunction

endpackage

// File: rtl/ipuc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipuc_in_if: frame byte stream channel
// Valid/ready channel carrying one frame byte and an end-of-frame flag.
// ----------------------------------------------------------------------------
interface ipuc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

// File: rtl/ipuc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipuc_out_if: checksum result channel
// Valid/ready channel carrying calculated and received checksums per frame.
// ----------------------------------------------------------------------------
interface ipuc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] ip_sum_calc;
	logic [15:0] ip_sum_recv;
	logic [15:0] udp_sum_calc;
	logic [15:0] udp_sum_recv;
	logic        truncated;

	modport source (output valid, output ip_sum_calc, output ip_sum_recv,
		output udp_sum_calc, output udp_sum_recv, output truncated, input ready);
	modport sink (input valid, input ip_sum_calc, input ip_sum_recv,
		input udp_sum_calc, input udp_sum_recv, input truncated, output ready);
endinterface

// File: rtl/ipuc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipuc_front: frame parser
// Tracks the byte position, decodes Ethernet/IPv4/UDP header fields, forms
// 16-bit words and issues sum commands to the queue.
// ----------------------------------------------------------------------------
module ipuc_front (
	input  logic              clk,
	input  logic              arst_n,
	ipuc_in_if.sink           frame,
	input  logic              q_full,
	output logic              q_push,
	output ipuc_pkg::ipuc_op_t q_op
);

	logic [ipuc_pkg::POS_W-1:0] pos_q;
	logic [15:0]                ether_kind_q;
	logic [5:0]                 header_bytes_q;
	logic [7:0]                 proto_q;
	logic [15:0]                udp_len_q;
	logic [7:0]                 pending_q;

	logic                       accept;
	logic [7:0]                 b;
	logic [15:0]                ether_now;
	logic [5:0]                 hl_now;
	logic [7:0]                 proto_now;
	logic [15:0]                udp_len_now;
	logic [7:0]                 pending_now;
	logic [ipuc_pkg::POS_W-1:0] hdr_end;
	logic [ipuc_pkg::POS_W-1:0] u;
	logic [5:0]                 off;
	logic [15:0]                extent;
	logic [15:0]                w;
	logic                       in_hdr;
	logic                       in_udp;
	ipuc_pkg::ipuc_op_t         op;

	assign frame.ready = !q_full;
	assign accept      = frame.valid && frame.ready;
	assign b           = frame.frame_byte;

	// Decode the current byte against the header layout
	always_comb begin
		ether_now   = ether_kind_q;
		hl_now      = header_bytes_q;
		proto_now   = proto_q;
		udp_len_now = udp_len_q;
		pending_now = pending_q;
		op          = '0;

		if (pos_q == ipuc_pkg::ETH_TYPE_HI) begin
			ether_now = {b, 8'h00};
		end else if (pos_q == ipuc_pkg::ETH_TYPE_LO) begin
			ether_now = ether_kind_q | {8'h00, b};
		end else if (pos_q == ipuc_pkg::ETH_HDR_BYTES) begin
			hl_now = {b[3:0], 2'b00};
		end

		hdr_end = ipuc_pkg::ETH_HDR_BYTES + {11'd0, hl_now};
		off     = 6'(pos_q - ipuc_pkg::ETH_HDR_BYTES);
		u       = pos_q - hdr_end;
		extent  = (udp_len_q < ipuc_pkg::UDP_HDR_BYTES) ? ipuc_pkg::UDP_HDR_BYTES : udp_len_q;
		w       = {pending_q, b};
		in_hdr  = (pos_q >= ipuc_pkg::ETH_HDR_BYTES) && (pos_q < hdr_end);
		in_udp  = !in_hdr && (pos_q > ipuc_pkg::ETH_HDR_BYTES)
			&& (hl_now >= ipuc_pkg::IP_MIN_HDR_BYTES) && (pos_q >= hdr_end);

		if (in_hdr) begin
			// IPv4 header: sum words, capture protocol and checksum field
			if (off == ipuc_pkg::IP_OFF_PROTO) begin
				proto_now = b;
			end
			if (!off[0]) begin
				pending_now = b;
			end else begin
				op.word = w;
				if (off == ipuc_pkg::IP_OFF_CSUM_LO) begin
					op.set_ip_field = 1'b1;
				end else begin
					op.add_ip = 1'b1;
				end
				if (off >= ipuc_pkg::IP_OFF_SRC_HI && off <= ipuc_pkg::IP_OFF_DST_LO) begin
					op.add_udp = 1'b1;
				end
			end
		end else if (in_udp) begin
			// UDP datagram: length capture, words, odd tail padded with zero
			if (u == ipuc_pkg::UDP_OFF_LEN_HI) begin
				udp_len_now = {b, 8'h00};
			end else if (u == ipuc_pkg::UDP_OFF_LEN_LO) begin
				udp_len_now = udp_len_q | {8'h00, b};
			end
			if (u <= ipuc_pkg::UDP_OFF_LEN_LO || u < {1'b0, extent}) begin
				if (!u[0]) begin
					pending_now = b;
					if (u >= ipuc_pkg::UDP_OFF_CSUM_HI && (u + 17'd1) == {1'b0, extent}) begin
						op.word    = {b, 8'h00};
						op.add_udp = 1'b1;
					end
				end else if (u == ipuc_pkg::UDP_OFF_CSUM_LO) begin
					op.word          = w;
					op.set_udp_field = 1'b1;
				end else begin
					// Length word counts twice: once in header, once in pseudo-header
					op.word    = (u == ipuc_pkg::UDP_OFF_LEN_LO) ? {w[14:0], w[15]} : w;
					op.add_udp = 1'b1;
				end
			end
		end

		op.last  = frame.frame_end;
		op.emit  = (ether_now == ipuc_pkg::ETHERTYPE_IPV4) && (proto_now == ipuc_pkg::IP_PROTO_UDP)
			&& (hl_now >= ipuc_pkg::IP_MIN_HDR_BYTES);
		op.trunc = pos_q < (hdr_end + ipuc_pkg::UDP_OFF_LEN_LO);
	end

	// Issue a command only when the back end has something to do
	assign q_push = accept
		&& (op.add_ip || op.add_udp || op.set_ip_field || op.set_udp_field || op.last);
	assign q_op   = op;

	// Advance parser state; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			ether_kind_q   <= '0;
			header_bytes_q <= '0;
			proto_q        <= '0;
			udp_len_q      <= '0;
			pending_q      <= '0;
		end else if (accept) begin
			if (frame.frame_end) begin
				pos_q          <= '0;
				ether_kind_q   <= '0;
				header_bytes_q <= '0;
				proto_q        <= '0;
				udp_len_q      <= '0;
				pending_q      <= '0;
			end else begin
				if (pos_q != ipuc_pkg::POS_MAX) begin
					pos_q <= pos_q + 17'd1;
				end
				ether_kind_q   <= ether_now;
				header_bytes_q <= hl_now;
				proto_q        <= proto_now;
				udp_len_q      <= udp_len_now;
				pending_q      <= pending_now;
			end
		end
	end

endmodule

// File: rtl/ipuc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipuc_queue: command queue
// Small register FIFO decoupling the parser from the sum engine.
// ----------------------------------------------------------------------------
module ipuc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ipuc_pkg::ipuc_op_t push_op,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output ipuc_pkg::ipuc_op_t head_op
);

	ipuc_pkg::ipuc_op_t           entry_q [ipuc_pkg::QDEPTH];
	logic [ipuc_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [ipuc_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [ipuc_pkg::QPTR_W:0]    count_q;
	logic                         do_push;
	logic                         do_pop;

	assign full       = (count_q == (ipuc_pkg::QPTR_W + 1)'(ipuc_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store a transaction at the write pointer
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/ipuc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipuc_back: checksum engine
// Applies queued commands to the IPv4 and UDP ones-complement sums and
// loads the result register on the final byte of a kept frame.
// ----------------------------------------------------------------------------
module ipuc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  ipuc_pkg::ipuc_op_t head_op,
	output logic               pop,
	ipuc_out_if.source         result
);

	logic [15:0] ip_accum_q;
	logic [15:0] udp_accum_q;
	logic [15:0] ip_field_q;
	logic [15:0] udp_field_q;
	logic        out_valid_q;

	logic [15:0] ip_next;
	logic [15:0] udp_next;
	logic [15:0] ip_field_next;
	logic [15:0] udp_field_next;
	logic        emit_now;

	// Apply one command to the running sums
	always_comb begin
		ip_next        = head_op.add_ip ? ipuc_pkg::oc_add(ip_accum_q, head_op.word) : ip_accum_q;
		udp_next       = head_op.add_udp ? ipuc_pkg::oc_add(udp_accum_q, head_op.word) : udp_accum_q;
		ip_field_next  = head_op.set_ip_field ? head_op.word : ip_field_q;
		udp_field_next = head_op.set_udp_field ? head_op.word : udp_field_q;
	end

	// Stall only a result transaction while the output register is occupied
	assign emit_now = head_op.last && head_op.emit;
	assign pop      = head_valid && (!emit_now || !out_valid_q || result.ready);

	// Update sums; reseed them after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_accum_q  <= '0;
			udp_accum_q <= ipuc_pkg::UDP_SUM_SEED;
			ip_field_q  <= '0;
			udp_field_q <= '0;
		end else if (pop) begin
			if (head_op.last) begin
				ip_accum_q  <= '0;
				udp_accum_q <= ipuc_pkg::UDP_SUM_SEED;
				ip_field_q  <= '0;
				udp_field_q <= '0;
			end else begin
				ip_accum_q  <= ip_next;
				udp_accum_q <= udp_next;
				ip_field_q  <= ip_field_next;
				udp_field_q <= udp_field_next;
			end
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit_now) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && emit_now) begin
			result.ip_sum_calc  <= ~ip_next;
			result.ip_sum_recv  <= ip_field_next;
			result.udp_sum_calc <= ~udp_next;
			result.udp_sum_recv <= udp_field_next;
			result.truncated    <= head_op.trunc;
		end
	end

	assign result.valid = out_valid_q;

endmodule

// File: rtl/ipv4_udp_checksum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_udp_checksum_checker: IPv4 header and UDP checksum checker
// Takes one Ethernet frame byte per cycle while the command queue is not full;
// the back end applies one ones-complement add per queued command.
// The final byte's command passes through the queue into the result register,
// and is held back while an untaken result stalls the queue.
// Reset (async, active low) clears parser state, queue and result valid.
// ----------------------------------------------------------------------------
module ipv4_udp_checksum_checker (
	input  logic       clk,
	input  logic       arst_n,
	ipuc_in_if.sink    frame,
	ipuc_out_if.source result
);

	logic               q_full;
	logic               q_push;
	ipuc_pkg::ipuc_op_t q_op;
	logic               q_pop;
	logic               q_head_valid;
	ipuc_pkg::ipuc_op_t q_head_op;

	// Parse bytes and issue commands
	ipuc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame),
		.q_full (q_full),
		.q_push (q_push),
		.q_op   (q_op)
	);

	// Decouple parser from sum engine
	ipuc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_op    (q_op),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_op    (q_head_op)
	);

	// Accumulate sums and deliver results
	ipuc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_op    (q_head_op),
		.pop        (q_pop),
		.result     (result)
	);

endmodule

// File: sim/ipv4_udp_checksum_checker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_udp_checksum_checker_test: frame-level check of the checksum checker
// Streams Ethernet frames byte by byte into the block and mirrors its parser
// and ones-complement sums in a scoreboard. Every result transaction is
// matched against the oldest predicted one. Directed frames cover short,
// truncated, padded, optioned and foreign frames; random frames
// follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module ipv4_udp_checksum_checker_test;

	// One checksum report as the result channel carries it
	typedef struct packed {
		logic [15:0] ip_calc;
		logic [15:0] ip_recv;
		logic [15:0] udp_calc;
		logic [15:0] udp_recv;
		logic        trunc;
	} csum_report_t;

	// Mirrors the parser state and keeps the reports still owed by the block
	class checksum_scoreboard;
		bit [ipuc_pkg::POS_W-1:0] pos;
		bit [15:0]      ether_type;
		bit [5:0]       hdr_len;
		bit [7:0]       proto;
		bit [15:0]      ip_sum;
		bit [15:0]      udp_sum;
		bit [15:0]      udp_len;
		bit [7:0]       hi_byte;
		bit [15:0]      ip_csum_seen;
		bit [15:0]      udp_csum_seen;
		csum_report_t   expected_reports[$];
		int unsigned    predicted;
		int unsigned    checked;
		int unsigned    trunc_seen;
		int unsigned    failures;

		function void clear_frame();
			pos = '0;
			ether_type = '0;
			hdr_len = '0;
			proto = '0;
			ip_sum = '0;
			udp_sum = '0;
			udp_len = '0;
			hi_byte = '0;
			ip_csum_seen = '0;
			udp_csum_seen = '0;
		endfunction

		function new();
			clear_frame();
		endfunction

		// Ones-complement add: fold the carry back into bit 0
		function bit [15:0] fold_add(bit [15:0] a, bit [15:0] b);
			bit [16:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[15:0] + {15'd0, s[16]};
		endfunction

		// Advance the parser by one accepted byte; queue a report at the end of an IPv4/UDP frame
		function void note_byte(bit [7:0] b, bit last);
			int unsigned p;
			int unsigned hl;
			int unsigned off;
			int unsigned u;
			int unsigned span;
			bit [15:0] w;
			csum_report_t r;
			p = pos;
			if (p == ipuc_pkg::ETH_TYPE_HI) begin
				ether_type = {b, 8'h00};
			end else if (p == ipuc_pkg::ETH_TYPE_LO) begin
				ether_type[7:0] = b;
			end else if (p == ipuc_pkg::ETH_HDR_BYTES) begin
				hdr_len = {b[3:0], 2'b00};
			end
			hl = hdr_len;
			w = {hi_byte, b};
			if (p >= ipuc_pkg::ETH_HDR_BYTES && p < ipuc_pkg::ETH_HDR_BYTES + hl) begin
				// IPv4 header words; source and destination also feed the pseudo-header
				off = p - ipuc_pkg::ETH_HDR_BYTES;
				if (off == ipuc_pkg::IP_OFF_PROTO) begin
					proto = b;
				end
				if ((off & 1) == 0) begin
					hi_byte = b;
				end else begin
					if (off == ipuc_pkg::IP_OFF_CSUM_LO) begin
						ip_csum_seen = w;
					end else begin
						ip_sum = fold_add(ip_sum, w);
					end
					if (off >= ipuc_pkg::IP_OFF_SRC_HI && off <= ipuc_pkg::IP_OFF_DST_LO) begin
						udp_sum = fold_add(udp_sum, w);
					end
				end
			end else if (p > ipuc_pkg::ETH_HDR_BYTES && hl >= ipuc_pkg::IP_MIN_HDR_BYTES
					&& p >= ipuc_pkg::ETH_HDR_BYTES + hl) begin
				// Datagram: sum up to the UDP length, at least the 8-byte header
				u = p - ipuc_pkg::ETH_HDR_BYTES - hl;
				span = (udp_len < ipuc_pkg::UDP_HDR_BYTES) ? ipuc_pkg::UDP_HDR_BYTES : udp_len;
				if (u == ipuc_pkg::UDP_OFF_LEN_HI) begin
					udp_len = {b, 8'h00};
				end else if (u == ipuc_pkg::UDP_OFF_LEN_LO) begin
					udp_len[7:0] = b;
				end
				if (u < ipuc_pkg::UDP_OFF_CSUM_HI || u < span) begin
					if ((u & 1) == 0) begin
						hi_byte = b;
						// odd final byte is padded with a zero low byte
						if (u >= ipuc_pkg::UDP_OFF_CSUM_HI && u + 1 == span) begin
							udp_sum = fold_add(udp_sum, {b, 8'h00});
						end
					end else if (u == ipuc_pkg::UDP_OFF_CSUM_LO) begin
						udp_csum_seen = w;
					end else begin
						udp_sum = fold_add(udp_sum, w);
						// length word counts once more for the pseudo-header
						if (u == ipuc_pkg::UDP_OFF_LEN_LO) begin
							udp_sum = fold_add(udp_sum, w);
						end
					end
				end
			end
			if (pos != ipuc_pkg::POS_MAX) begin
				pos = pos + 1'b1;
			end
			if (last) begin
				if (ether_type == ipuc_pkg::ETHERTYPE_IPV4 && proto == ipuc_pkg::IP_PROTO_UDP
						&& hl >= ipuc_pkg::IP_MIN_HDR_BYTES) begin
					r.ip_calc = ~ip_sum;
					r.ip_recv = ip_csum_seen;
					r.udp_calc = ~fold_add(udp_sum, ipuc_pkg::UDP_SUM_SEED);
					r.udp_recv = udp_csum_seen;
					r.trunc = (p < ipuc_pkg::ETH_HDR_BYTES + hl + ipuc_pkg::UDP_OFF_LEN_LO);
					expected_reports.push_back(r);
					predicted++;
				end
				clear_frame();
			end
		endfunction

		// Compare one result transaction with the oldest prediction
		function void check_result(csum_report_t got);
			csum_report_t exp;
			if (expected_reports.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("unexpected report: ip %h/%h udp %h/%h trunc %b",
						got.ip_calc, got.ip_recv, got.udp_calc, got.udp_recv, got.trunc);
				end
				return;
			end
			exp = expected_reports.pop_front();
			checked++;
			if (got.trunc === 1'b1) begin
				trunc_seen++;
			end
			if (got.ip_calc !== exp.ip_calc || got.ip_recv !== exp.ip_recv
					|| got.udp_calc !== exp.udp_calc || got.udp_recv !== exp.udp_recv
					|| got.trunc !== exp.trunc) begin
				failures++;
				if (failures <= 10) begin
					$display("report %0d mismatch (exp/got): ip calc %h/%h recv %h/%h",
						checked, exp.ip_calc, got.ip_calc, exp.ip_recv, got.ip_recv);
					$display("  udp calc %h/%h recv %h/%h trunc %b/%b",
						exp.udp_calc, got.udp_calc, exp.udp_recv, got.udp_recv,
						exp.trunc, got.trunc);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int unsigned cyc = 0;
	int unsigned frames_sent = 0;
	int unsigned bytes_sent = 0;
	bit [7:0] frame_q[$];
	checksum_scoreboard sb = new();

	ipuc_in_if  frame_if();
	ipuc_out_if result_if();

	ipv4_udp_checksum_checker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_if),
		.result (result_if)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// Random idle decision; idling is switched off in a recurring window
	function automatic bit idle_now();
		if (cyc % 3000 >= 2300) begin
			return 1'b0;
		end
		return $urandom_range(99) < 13;
	endfunction

	// Sample result transactions and stall the result channel at random
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			sb.check_result({result_if.ip_sum_calc, result_if.ip_sum_recv,
				result_if.udp_sum_calc, result_if.udp_sum_recv, result_if.truncated});
		end
		result_if.ready <= !idle_now();
	end

	// Drive one byte until accepted, inserting random idle cycles first
	task automatic send_byte(input bit [7:0] b, input bit last);
		while (idle_now()) begin
			frame_if.valid <= 1'b0;
			@(posedge clk);
		end
		frame_if.valid <= 1'b1;
		frame_if.frame_byte <= b;
		frame_if.frame_end <= last;
		@(posedge clk);
		while (!frame_if.ready) begin
			@(posedge clk);
		end
		sb.note_byte(b, last);
		bytes_sent++;
	endtask

	// Send the first n bytes of the built frame, flagging the last of them
	task automatic send_frame(input int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			send_byte(frame_q[i], i == n - 1);
		end
		frames_sent++;
	endtask

	// Build a frame: random MACs, ethertype, IPv4 header, datagram of dgram_n bytes
	function automatic void build_frame(bit [15:0] etype, bit [3:0] ihl, bit [7:0] ip_proto,
			bit [15:0] ulen, int unsigned dgram_n);
		int unsigned hdr_n;
		frame_q.delete();
		hdr_n = (ihl < 5) ? 20 : ihl * 4;
		repeat (12) frame_q.push_back(8'($urandom_range(255)));
		frame_q.push_back(etype[15:8]);
		frame_q.push_back(etype[7:0]);
		for (int unsigned i = 0; i < hdr_n; i++) begin
			if (i == 0) begin
				frame_q.push_back({4'h4, ihl});
			end else if (i == ipuc_pkg::IP_OFF_PROTO) begin
				frame_q.push_back(ip_proto);
			end else begin
				frame_q.push_back(8'($urandom_range(255)));
			end
		end
		for (int unsigned i = 0; i < dgram_n; i++) begin
			if (i == ipuc_pkg::UDP_OFF_LEN_HI) begin
				frame_q.push_back(ulen[15:8]);
			end else if (i == ipuc_pkg::UDP_OFF_LEN_LO) begin
				frame_q.push_back(ulen[7:0]);
			end else begin
				frame_q.push_back(8'($urandom_range(255)));
			end
		end
	endfunction

	// Overwrite every byte except ethertype, version/IHL and protocol
	function automatic void flood(bit [7:0] v);
		for (int unsigned i = 0; i < frame_q.size(); i++) begin
			if (i != ipuc_pkg::ETH_TYPE_HI && i != ipuc_pkg::ETH_TYPE_LO
					&& i != ipuc_pkg::ETH_HDR_BYTES
					&& i != ipuc_pkg::ETH_HDR_BYTES + ipuc_pkg::IP_OFF_PROTO) begin
				frame_q[i] = v;
			end
		end
	endfunction

	// One random frame: mostly well-formed UDP, some cut short, some noise
	task automatic random_frame();
		int unsigned kind;
		int unsigned ihl;
		int unsigned pay;
		int unsigned tail;
		bit [15:0] ulen;
		int unsigned n;
		kind = $urandom_range(99);
		ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
		pay = $urandom_range(24);
		tail = ($urandom_range(4) == 0) ? $urandom_range(6, 1) : 0;
		case ($urandom_range(7))
			0: ulen = 16'($urandom_range(7));
			1: ulen = 16'($urandom_range(40));
			2: ulen = 16'hFFFF;
			3: ulen = 16'($urandom_range(16'hFFFF));
			default: ulen = 16'(ipuc_pkg::UDP_HDR_BYTES + pay);
		endcase
		if (kind < 82) begin
			build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'(ihl), ipuc_pkg::IP_PROTO_UDP, ulen,
				ipuc_pkg::UDP_HDR_BYTES + pay + tail);
			n = (kind < 70) ? frame_q.size() : $urandom_range(frame_q.size(), 1);
		end else begin
			// noise: random bytes, sometimes dressed as IPv4 carrying UDP
			frame_q.delete();
			n = $urandom_range(80, 1);
			repeat (n) frame_q.push_back(8'($urandom_range(255)));
			if (n > 14 && $urandom_range(1) == 1) begin
				frame_q[ipuc_pkg::ETH_TYPE_HI] = ipuc_pkg::ETHERTYPE_IPV4[15:8];
				frame_q[ipuc_pkg::ETH_TYPE_LO] = ipuc_pkg::ETHERTYPE_IPV4[7:0];
				if (n > 23 && $urandom_range(1) == 1) begin
					frame_q[ipuc_pkg::ETH_HDR_BYTES + ipuc_pkg::IP_OFF_PROTO] =
						ipuc_pkg::IP_PROTO_UDP;
				end
			end
		end
		send_frame(n);
	endtask

	initial begin
		int unsigned drain;
		arst_n = 1'b0;
		frame_if.valid = 1'b0;
		frame_if.frame_byte = '0;
		frame_if.frame_end = 1'b0;
		result_if.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: minimal datagram, odd padding, options, extremes
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd5, ipuc_pkg::IP_PROTO_UDP, 16'd8, 8);
		send_frame(frame_q.size());
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd5, ipuc_pkg::IP_PROTO_UDP, 16'd9, 9);
		send_frame(frame_q.size());
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd5, ipuc_pkg::IP_PROTO_UDP, 16'd13, 13);
		send_frame(frame_q.size());
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd6, ipuc_pkg::IP_PROTO_UDP, 16'd12, 12);
		send_frame(frame_q.size());
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd15, ipuc_pkg::IP_PROTO_UDP, 16'd12, 12);
		send_frame(frame_q.size());
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd15, ipuc_pkg::IP_PROTO_UDP, 16'hFFFF, 40);
		flood(8'hFF);
		send_frame(frame_q.size());
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd5, ipuc_pkg::IP_PROTO_UDP, 16'd0, 20);
		flood(8'h00);
		send_frame(frame_q.size());
		// length below the UDP header size, then bytes past the length extent
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd5, ipuc_pkg::IP_PROTO_UDP, 16'd3, 14);
		send_frame(frame_q.size());
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd5, ipuc_pkg::IP_PROTO_UDP, 16'd10, 30);
		send_frame(frame_q.size());
		// cut short: before protocol, inside header, around the UDP length
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd5, ipuc_pkg::IP_PROTO_UDP, 16'd20, 20);
		send_frame(ipuc_pkg::ETH_HDR_BYTES + 5);
		send_frame(ipuc_pkg::ETH_HDR_BYTES + 15);
		send_frame(ipuc_pkg::ETH_HDR_BYTES + 20 + 5);
		send_frame(ipuc_pkg::ETH_HDR_BYTES + 20 + 6);
		send_frame(ipuc_pkg::ETH_HDR_BYTES + 20 + 11);
		// frames that give no report
		build_frame(16'h86DD, 4'd5, ipuc_pkg::IP_PROTO_UDP, 16'd8, 8);
		send_frame(frame_q.size());
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd5, 8'd6, 16'd8, 8);
		send_frame(frame_q.size());
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd4, ipuc_pkg::IP_PROTO_UDP, 16'd8, 8);
		send_frame(frame_q.size());
		build_frame(ipuc_pkg::ETHERTYPE_IPV4, 4'd0, ipuc_pkg::IP_PROTO_UDP, 16'd8, 8);
		send_frame(frame_q.size());
		send_frame(1);
		send_frame(ipuc_pkg::ETH_TYPE_HI + 1);

		// Random frames until enough bytes have gone through
		while (bytes_sent < 1450) begin
			random_frame();
		end
		frame_if.valid <= 1'b0;

		// Drain outstanding reports, then watch for strays
		drain = 0;
		while (sb.expected_reports.size() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (sb.expected_reports.size() != 0) begin
			$display("%0d predicted reports never arrived", sb.expected_reports.size());
			sb.failures += sb.expected_reports.size();
		end

		$display("covered %0d frames, %0d bytes (short, cut, padded and foreign among them)",
			frames_sent, bytes_sent);
		$display("checked %0d reports, %0d truncated, %0d failures",
			sb.checked, sb.trunc_seen, sb.failures);
		if (sb.failures == 0) begin
			$display("ipv4_udp_checksum_checker_test OK");
		end else begin
			$display("ipv4_udp_checksum_checker_test NOT OK");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#25ms;
		$display("timeout after %0d cycles", cyc);
		$display("ipv4_udp_checksum_checker_test NOT OK");
		$finish;
	end

endmodule
